/* rtl/core/ksm_pkg.sv */
// Shared constants and controller/datapath interface types for the k-way merge block.
`timescale 1ns / 1ps

package ksm_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int MAX_LISTS_DEF    = 16;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage

/* rtl/core/ksm_ctrl.sv */
// Sequencing state machine for list loading, head scans and result emission.
`timescale 1ns / 1ps

module ksm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  ksm_pkg::t_status i_status,
    output ksm_pkg::t_cmd    o_cmd,
    output logic             o_in_ready
);
    import ksm_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_LOAD;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/ksm_datapath.sv */
// Element and list stores, head scan pipeline, counters and output register.
`timescale 1ns / 1ps

module ksm_datapath #(
    parameter int MAX_ELEMENTS = ksm_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_LISTS    = ksm_pkg::MAX_LISTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ksm_pkg::t_cmd                      i_cmd,
    input  logic signed [ksm_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_start,
    input  logic                               i_out_ready,
    output ksm_pkg::t_status                   o_status,
    output logic                               o_out_valid,
    output logic signed [ksm_pkg::DATA_W-1:0]  o_out_value,
    output logic                               o_out_last,
    output logic                               o_out_ovf
);
    import ksm_pkg::*;

    localparam int PW   = $clog2(MAX_ELEMENTS + 1);
    localparam int EA_W = $clog2(MAX_ELEMENTS);
    localparam int LC_W = $clog2(MAX_LISTS + 2);
    localparam int LA_W = $clog2(MAX_LISTS);

    logic [DATA_W-1:0] r_elem_mem [MAX_ELEMENTS];
    logic [PW-1:0]     r_head_mem [MAX_LISTS];
    logic [PW-1:0]     r_end_mem  [MAX_LISTS];

    logic [LC_W-1:0] r_lcnt, n_lcnt;
    logic [PW-1:0]   r_ecnt, n_ecnt;
    logic [PW-1:0]   r_emitted, n_emitted;
    logic            r_ovf, n_ovf;
    logic            r_drop, n_drop;

    logic [LC_W-1:0] r_cnt;
    logic            r_s1_vld;
    logic [LA_W-1:0] r_s1_idx;
    logic [PW-1:0]   r_head_q;
    logic [PW-1:0]   r_end_q;
    logic            r_s2_vld;
    logic [LA_W-1:0] r_s2_idx;
    logic [PW-1:0]   r_s2_pos;
    logic [DATA_W-1:0] r_elem_q;

    logic                     r_best_found;
    logic [LA_W-1:0]          r_best_idx;
    logic [PW-1:0]            r_best_pos;
    logic signed [DATA_W-1:0] r_best_val;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_ovf;

    logic            ld_start;
    logic            ld_full;
    logic            ld_lfull;
    logic            ld_open;
    logic            ld_app;
    logic            ld_store;
    logic            ld_reject;
    logic [LC_W-1:0] ld_lm1;
    logic [LA_W-1:0] end_wa;
    logic            scan_issue;
    logic            best_take;
    logic            emit_last;

    assign ld_start  = i_start || (r_lcnt == '0);
    assign ld_full   = (r_ecnt == PW'(MAX_ELEMENTS));
    assign ld_lfull  = (r_lcnt == LC_W'(MAX_LISTS));
    assign ld_open   = i_cmd.load && ld_start && !ld_full && !ld_lfull;
    assign ld_app    = i_cmd.load && !ld_start && !r_drop && !ld_full;
    assign ld_store  = ld_open || ld_app;
    assign ld_reject = i_cmd.load && !ld_store;
    assign ld_lm1    = r_lcnt - LC_W'(1);
    assign end_wa    = ld_open ? r_lcnt[LA_W-1:0] : ld_lm1[LA_W-1:0];

    assign scan_issue = i_cmd.scan_step && (r_cnt < r_lcnt);
    assign best_take  = r_s2_vld && (!r_best_found || ($signed(r_elem_q) < r_best_val));
    assign emit_last  = ((r_emitted + PW'(1)) == r_ecnt);

    assign o_status.scan_done = (r_cnt == (r_lcnt + LC_W'(1)));
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.emit_last = emit_last;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (ld_store) begin
            r_elem_mem[r_ecnt[EA_W-1:0]] <= i_value;
        end
        r_elem_q <= r_elem_mem[r_head_q[EA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ld_store) begin
            r_end_mem[end_wa] <= r_ecnt + PW'(1);
        end
        if (scan_issue) begin
            r_end_q <= r_end_mem[r_cnt[LA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_open) begin
            r_head_mem[r_lcnt[LA_W-1:0]] <= r_ecnt;
        end else if (i_cmd.emit) begin
            r_head_mem[r_best_idx] <= r_best_pos + PW'(1);
        end
        if (scan_issue) begin
            r_head_q <= r_head_mem[r_cnt[LA_W-1:0]];
        end
    end

    always_comb begin
        n_lcnt    = r_lcnt;
        n_ecnt    = r_ecnt;
        n_emitted = r_emitted;
        n_ovf     = r_ovf;
        n_drop    = r_drop;
        if (ld_store) begin
            n_ecnt = r_ecnt + PW'(1);
        end
        if (ld_open) begin
            n_lcnt = r_lcnt + LC_W'(1);
            n_drop = 1'b0;
        end
        if (ld_reject) begin
            n_ovf = 1'b1;
            if (ld_start) begin
                n_drop = 1'b1;
            end
        end
        if (i_cmd.emit) begin
            if (emit_last) begin
                n_lcnt    = '0;
                n_ecnt    = '0;
                n_emitted = '0;
                n_ovf     = 1'b0;
                n_drop    = 1'b0;
            end else begin
                n_emitted = r_emitted + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt       <= '0;
            r_ecnt       <= '0;
            r_emitted    <= '0;
            r_ovf        <= 1'b0;
            r_drop       <= 1'b0;
            r_cnt        <= '0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_lcnt    <= n_lcnt;
            r_ecnt    <= n_ecnt;
            r_emitted <= n_emitted;
            r_ovf     <= n_ovf;
            r_drop    <= n_drop;
            if (i_cmd.scan_start) begin
                r_cnt <= '0;
            end else if (i_cmd.scan_step) begin
                r_cnt <= r_cnt + LC_W'(1);
            end
            r_s1_vld <= scan_issue;
            r_s2_vld <= r_s1_vld && (r_head_q < r_end_q);
            if (i_cmd.scan_start) begin
                r_best_found <= 1'b0;
            end else if (best_take) begin
                r_best_found <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_cnt[LA_W-1:0];
        r_s2_idx <= r_s1_idx;
        r_s2_pos <= r_head_q;
        if (best_take) begin
            r_best_idx <= r_s2_idx;
            r_best_pos <= r_s2_pos;
            r_best_val <= $signed(r_elem_q);
        end
        if (i_cmd.emit) begin
            r_out_value <= r_best_val;
            r_out_last  <= emit_last;
            r_out_ovf   <= r_ovf;
        end
    end

endmodule

/* rtl/core/k_way_sorted_list_merge.sv */
// Top level of the k-way sorted list merge block.
`timescale 1ns / 1ps

// Elements of up to MAX_LISTS ascending lists are loaded one per cycle; a request with
// starts_new_list opens a list, and the request with last_of_all starts the merge. Lists or
// elements beyond MAX_LISTS / MAX_ELEMENTS are dropped and flagged on every result of the
// burst. During the burst the input is not ready. Every result needs a full scan of the
// per-list head and end memories through a three-stage read pipeline into the element
// memory, followed by an emit step that loads the output register and advances the winning
// list. Ties go to the lower list. Loading of the next set resumes as soon as the final
// result enters the output register, and output stalls delay each result until the
// output register is free.

module k_way_sorted_list_merge #(
    parameter int MAX_ELEMENTS = ksm_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_LISTS    = ksm_pkg::MAX_LISTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [ksm_pkg::DATA_W-1:0] i_value,
    input  logic                              i_starts_new_list,
    input  logic                              i_last_of_all,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [ksm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_last_out,
    output logic                              o_overflow
);
    import ksm_pkg::*;

    t_cmd    cmd;
    t_status status;

    ksm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_last  (i_last_of_all),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_ready)
    );

    ksm_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_LISTS    (MAX_LISTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_start     (i_starts_new_list),
        .i_out_ready (i_ready),
        .o_status    (status),
        .o_out_valid (o_valid),
        .o_out_value (o_merged_value),
        .o_out_last  (o_last_out),
        .o_out_ovf   (o_overflow)
    );

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("Result loaded while the output register was still occupied.");

    a_no_load_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !cmd.scan_step && !cmd.emit)
        else $error("Input request accepted during a merge burst.");

    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && status.emit_last) |=> o_ready)
        else $error("Input not reopened after the final result of a burst.");

    a_scan_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_start |=> !o_ready)
        else $error("Input ready while a head scan is running.");

endmodule
